// ===== hdl/vertex_weld_hash_table_macros.svh =====
// Assertion macros shared by the vertex weld checker.
`ifndef VERTEX_WELD_HASH_TABLE_MACROS_SVH
`define VERTEX_WELD_HASH_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VWHT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertex weld same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VWHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vertex weld next-cycle check failed");

`endif

// ===== hdl/vwht_pkg.sv =====
// Types and constants shared by the vertex weld hash table files.
package vwht_pkg;

    localparam int WORD_W  = 32;
    localparam int WORDS   = 6;
    localparam int SLOT_W  = 16;
    localparam int IDX_W   = 12;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] FNV_BASIS  = 32'd2166136261;
    localparam logic [WORD_W-1:0] FNV_PRIME  = 32'd16777619;
    localparam logic [SLOT_W-1:0] SLOT_EMPTY = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_WELD_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VERTICES    = 2'd2;

    typedef enum logic [1:0] {
        STATUS_APPENDED     = 2'd0,
        STATUS_REUSED       = 2'd1,
        STATUS_TABLE_FULL   = 2'd2,
        STATUS_VERTEX_LIMIT = 2'd3
    } status_t;

endpackage

// ===== hdl/vwht_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module vwht_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/vertex_weld_hash_table.sv =====
// Top level of the vertex weld hash table: hashing, probing and vertex append.
//
// Usage: an item is offered on start with kind and the six corner words, and is
// taken at a clock edge where start is high and busy is low. A corner item
// (kind 0) yields exactly one result: done pulses high for one cycle while
// vertex_index and status hold the outcome. A clear item (kind 1) yields no
// result; it empties the slot table and restarts the vertex count.
// Configuration registers (weld enable, table size, vertex limit) are written
// through cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
// high, and writes are expected only while busy is low.
// Sequence: with welding enabled the FNV-1a hash runs over one shared 32x32
// multiplier, one word per cycle, through the six words. Each probe then
// reads the table (ST_PROBE_RD) and checks the entry (ST_PROBE_CHK), plus a
// vertex store check (ST_STORE_CHK) when the slot is occupied; an empty slot
// leads to ST_APPEND, which appends. With welding off a corner goes straight
// to ST_APPEND. No new item is taken while busy is high; done rises as busy
// falls, so the next item can be taken while done is high.
// Reset and clear: the slot table is swept one entry per cycle, and busy stays
// high until the whole table is swept, after reset and after each clear item.
// The receiver cannot stall: each result is shown for exactly one cycle.
module vertex_weld_hash_table
    import vwht_pkg::*;
#(
    parameter int TABLE_DEPTH  = 8192,
    parameter int VERTEX_DEPTH = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 kind,
    input  logic [WORD_W-1:0]    pos_x,
    input  logic [WORD_W-1:0]    pos_y,
    input  logic [WORD_W-1:0]    pos_z,
    input  logic [WORD_W-1:0]    norm_x,
    input  logic [WORD_W-1:0]    norm_y,
    input  logic [WORD_W-1:0]    norm_z,
    output logic                 done,
    output logic [IDX_W-1:0]     vertex_index,
    output logic [1:0]           status,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Slot table address, probe count and vertex store widths.
    localparam int TW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int VW = $clog2(VERTEX_DEPTH + 1);
    localparam int ROW_W = WORDS * WORD_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_STORE_CHK,
        ST_APPEND
    } state_t;

    // Control registers.
    state_t            state_reg, state_next;
    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic [IDX_W-1:0]  vidx_reg, vidx_next;
    logic [VW-1:0]     vertex_total_reg, vertex_total_next;
    logic [TW-1:0]     clr_addr_reg, clr_addr_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              have_slot_reg, have_slot_next;

    // Configuration registers.
    logic              weld_en_reg;
    logic [3:0]        tsl_reg;
    logic [CFG_W-1:0]  maxv_reg;

    // Working registers of the current item.
    logic [WORD_W-1:0] word_reg [WORDS];
    logic [WORD_W-1:0] h_reg, h_next;
    logic [TW-1:0]     slot_reg, slot_next;
    logic [TW-1:0]     mask_reg, mask_next;
    logic [NW-1:0]     n_reg, n_next;
    logic [NW-1:0]     probes_reg, probes_next;
    logic [SLOT_W-1:0] entry_reg, entry_next;

    // Memory ports.
    logic              tbl_we;
    logic [TW-1:0]     tbl_waddr;
    logic [SLOT_W-1:0] tbl_wdata;
    logic [SLOT_W-1:0] tbl_rdata;
    logic              st_we;
    logic [ROW_W-1:0]  st_rdata;
    logic [AW-1:0]     st_raddr;

    // Helpers.
    logic              accept;
    logic [ROW_W-1:0]  words_cat;
    logic [WORD_W-1:0] h_xor;
    logic [WORD_W-1:0] h_mul;
    logic [3:0]        lg_eff;
    logic [31:0]       pow32;
    logic [31:0]       n32;
    logic [31:0]       limit32;
    logic              at_limit;
    logic              entry_ok;
    logic              last_probe;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done         = done_reg;
    assign vertex_index = vidx_reg;
    assign status       = status_reg;

    assign words_cat = {word_reg[0], word_reg[1], word_reg[2],
                        word_reg[3], word_reg[4], word_reg[5]};

    // One FNV-1a step per cycle: xor in a word, then multiply by the prime.
    assign h_xor = h_reg ^ word_reg[cnt_reg];
    assign h_mul = h_xor * FNV_PRIME;

    // Slots in use: 2^table_size_log2, at least two, at most TABLE_DEPTH.
    assign lg_eff = (tsl_reg == 4'd0) ? 4'd1 : tsl_reg;
    assign pow32  = 32'd1 << lg_eff;
    assign n32    = (pow32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : pow32;

    // Vertex limit saturates at the store depth.
    assign limit32  = (32'(maxv_reg) > 32'(VERTEX_DEPTH)) ? 32'(VERTEX_DEPTH)
                                                          : 32'(maxv_reg);
    assign at_limit = 32'(vertex_total_reg) >= limit32;

    assign entry_ok   = 32'(tbl_rdata) < 32'(VERTEX_DEPTH);
    assign last_probe = (probes_reg + NW'(1)) == n_reg;

    // The store is read at whatever index the table returned last cycle.
    assign st_raddr = tbl_rdata[AW-1:0];

    vwht_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (slot_reg),
        .rdata (tbl_rdata)
    );

    vwht_ram #(
        .WIDTH (ROW_W),
        .DEPTH (VERTEX_DEPTH)
    ) u_store_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (vertex_total_reg[AW-1:0]),
        .wdata (words_cat),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    always_comb
    begin
        state_next        = state_reg;
        done_next         = 1'b0;
        status_next       = status_reg;
        vidx_next         = vidx_reg;
        vertex_total_next = vertex_total_reg;
        clr_addr_next     = clr_addr_reg;
        cnt_next          = cnt_reg;
        have_slot_next    = have_slot_reg;
        h_next            = h_reg;
        slot_next         = slot_reg;
        mask_next         = mask_reg;
        n_next            = n_reg;
        probes_next       = probes_reg;
        entry_next        = entry_reg;
        tbl_we            = 1'b0;
        tbl_waddr         = slot_reg;
        tbl_wdata         = SLOT_EMPTY;
        st_we             = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = clr_addr_reg;
                if (clr_addr_reg == TW'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + TW'(1);
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind)
                    begin
                        vertex_total_next = '0;
                        clr_addr_next     = '0;
                        state_next        = ST_CLEAR;
                    end
                    else if (weld_en_reg)
                    begin
                        cnt_next   = '0;
                        h_next     = FNV_BASIS;
                        state_next = ST_HASH;
                    end
                    else
                    begin
                        have_slot_next = 1'b0;
                        state_next     = ST_APPEND;
                    end
                end
            end

            ST_HASH:
            begin
                h_next   = h_mul;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'(WORDS - 1))
                begin
                    n_next         = NW'(n32);
                    mask_next      = TW'(n32 - 32'd1);
                    slot_next      = h_mul[TW-1:0] & TW'(n32 - 32'd1);
                    probes_next    = '0;
                    have_slot_next = 1'b0;
                    state_next     = ST_PROBE_RD;
                end
            end

            ST_PROBE_RD:
            begin
                state_next = ST_PROBE_CHK;
            end

            ST_PROBE_CHK:
            begin
                entry_next = tbl_rdata;
                if (tbl_rdata == SLOT_EMPTY)
                begin
                    have_slot_next = 1'b1;
                    state_next     = ST_APPEND;
                end
                else if (entry_ok)
                begin
                    state_next = ST_STORE_CHK;
                end
                else if (last_probe)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_TABLE_FULL;
                    vidx_next   = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    probes_next = probes_reg + NW'(1);
                    slot_next   = (slot_reg + TW'(1)) & mask_reg;
                    state_next  = ST_PROBE_RD;
                end
            end

            ST_STORE_CHK:
            begin
                if (st_rdata == words_cat)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_REUSED;
                    vidx_next   = entry_reg[IDX_W-1:0];
                    state_next  = ST_IDLE;
                end
                else if (last_probe)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_TABLE_FULL;
                    vidx_next   = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    probes_next = probes_reg + NW'(1);
                    slot_next   = (slot_reg + TW'(1)) & mask_reg;
                    state_next  = ST_PROBE_RD;
                end
            end

            ST_APPEND:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (at_limit)
                begin
                    status_next = STATUS_VERTEX_LIMIT;
                    vidx_next   = '0;
                end
                else
                begin
                    st_we             = 1'b1;
                    tbl_we            = have_slot_reg;
                    tbl_waddr         = slot_reg;
                    tbl_wdata         = SLOT_W'(vertex_total_reg);
                    status_next       = STATUS_APPENDED;
                    vidx_next         = IDX_W'(vertex_total_reg);
                    vertex_total_next = vertex_total_reg + VW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State machine and registered result outputs. Reset starts a table sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            done_reg         <= 1'b0;
            status_reg       <= STATUS_APPENDED;
            vidx_reg         <= '0;
            vertex_total_reg <= '0;
            clr_addr_reg     <= '0;
            cnt_reg          <= '0;
            have_slot_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            done_reg         <= done_next;
            status_reg       <= status_next;
            vidx_reg         <= vidx_next;
            vertex_total_reg <= vertex_total_next;
            clr_addr_reg     <= clr_addr_next;
            cnt_reg          <= cnt_next;
            have_slot_reg    <= have_slot_next;
        end
    end

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weld_en_reg <= 1'b1;
            tsl_reg     <= 4'd13;
            maxv_reg    <= 13'd4096;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WELD_ENABLE:     weld_en_reg <= cfg_data[0];
                CFG_TABLE_SIZE_LOG2: tsl_reg     <= cfg_data[3:0];
                CFG_MAX_VERTICES:    maxv_reg    <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Item words and probe working state carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg[0] <= pos_x;
            word_reg[1] <= pos_y;
            word_reg[2] <= pos_z;
            word_reg[3] <= norm_x;
            word_reg[4] <= norm_y;
            word_reg[5] <= norm_z;
        end
        h_reg      <= h_next;
        slot_reg   <= slot_next;
        mask_reg   <= mask_next;
        n_reg      <= n_next;
        probes_reg <= probes_next;
        entry_reg  <= entry_next;
    end

endmodule

// ===== hdl/vwht_checker.sv =====
// Port-level checker for the vertex weld hash table, bound to the top level.
`include "vertex_weld_hash_table_macros.svh"

module vwht_checker
    import vwht_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             kind,
    input logic             done,
    input logic [IDX_W-1:0] vertex_index,
    input logic [1:0]       status
);

    // An accepted item always shows busy in the cycle after its acceptance.
    `VWHT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // Each item gives at most one result, so results never come back to back.
    `VWHT_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)

    // A failed corner reports index zero.
    `VWHT_ASSERT_IMPL(a_fail_index, clk, rst_n,
        done && (status == STATUS_TABLE_FULL || status == STATUS_VERTEX_LIMIT),
        vertex_index == '0)

    // A clear item produces no result.
    `VWHT_ASSERT_NEXT(a_clear_silent, clk, rst_n, start && !busy && kind, !done)

endmodule

bind vertex_weld_hash_table vwht_checker u_vwht_checker (.*);

// ===== sim/vertex_weld_hash_table_test.sv =====
// Self-checking testbench for the vertex weld hash table: directed cases, then random mesh traffic.
module vertex_weld_hash_table_test
    import vwht_pkg::*;
();

    // Depths of the block as instantiated (its defaults).
    localparam int TABLE_SLOTS = 8192;
    localparam int STORE_DEPTH = 4096;

    // The random part runs in phases, each with its own register setting.
    localparam int RANDOM_PHASES   = 30;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int POOL_LIMIT      = 24;

    // A corner is six raw words: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z.
    typedef logic [WORDS-1:0][WORD_W-1:0] corner_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        status_t          outcome;
    } weld_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 kind      = 1'b0;
    logic [WORD_W-1:0]    pos_x     = '0;
    logic [WORD_W-1:0]    pos_y     = '0;
    logic [WORD_W-1:0]    pos_z     = '0;
    logic [WORD_W-1:0]    norm_x    = '0;
    logic [WORD_W-1:0]    norm_y    = '0;
    logic [WORD_W-1:0]    norm_z    = '0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_WELD_ENABLE;
    logic [CFG_W-1:0]     cfg_data  = '0;
    wire                  busy;
    wire                  done;
    wire                  cfg_ready;
    wire  [IDX_W-1:0]     vertex_index;
    wire  [1:0]           status;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    vertex_weld_hash_table u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .norm_x       (norm_x),
        .norm_y       (norm_y),
        .norm_z       (norm_z),
        .done         (done),
        .vertex_index (vertex_index),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Shadow copy of the block's state and registers, kept in step with
    // every accepted item and every register write.
    logic [SLOT_W-1:0] slot_shadow [TABLE_SLOTS];
    corner_t           vertex_store [STORE_DEPTH];
    int                shadow_total;
    logic              weld_on;
    logic [3:0]        size_log2;
    logic [CFG_W-1:0]  vertex_limit;

    // Outcomes of accepted corners whose result has not been seen yet.
    weld_result_t      awaited_welds [$];

    // Recently sent corners, replayed so that welding really happens.
    corner_t           mesh_pool [$];

    int  fault_count     = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  status_seen [4] = '{0, 0, 0, 0};
    bit  sender_idles    = 1'b1;

    // Word-wise FNV-1a over the six words, all arithmetic modulo 2^32.
    function automatic logic [WORD_W-1:0] fnv1a_corner(corner_t c);
        logic [WORD_W-1:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < WORDS; i++)
        begin
            h = h ^ c[i];
            h = h * FNV_PRIME;
        end
        return h;
    endfunction

    function automatic void clear_shadow();
        for (int i = 0; i < TABLE_SLOTS; i++)
            slot_shadow[i] = SLOT_EMPTY;
        shadow_total = 0;
    endfunction

    // Works out what one corner yields and applies its effect on the shadow state.
    // A match wins over the vertex limit; no match and no empty slot means the
    // table is full, and only after that is the vertex limit looked at.
    function automatic void weld_corner(corner_t c);
        int                lg;
        int                span;
        int                slot;
        int                slot_pick;
        int                limit;
        logic [WORD_W-1:0] h;
        logic [SLOT_W-1:0] entry;
        bit                have_slot;
        weld_result_t      r;
        have_slot = 1'b0;
        slot_pick = 0;
        if (weld_on)
        begin
            // A size of zero acts as two slots; sizes past the table saturate.
            lg = (size_log2 < 4'd1) ? 1 : int'(size_log2);
            span = 1 << lg;
            if (span > TABLE_SLOTS)
                span = TABLE_SLOTS;
            h = fnv1a_corner(c);
            for (int p = 0; p < span; p++)
            begin
                slot = int'((h + WORD_W'(p)) & WORD_W'(span - 1));
                entry = slot_shadow[slot];
                if (entry == SLOT_EMPTY)
                begin
                    slot_pick = slot;
                    have_slot = 1'b1;
                    break;
                end
                if (entry < STORE_DEPTH && vertex_store[entry] == c)
                begin
                    r.index = entry[IDX_W-1:0];
                    r.outcome = STATUS_REUSED;
                    awaited_welds.push_back(r);
                    return;
                end
            end
            if (!have_slot)
            begin
                r.index = '0;
                r.outcome = STATUS_TABLE_FULL;
                awaited_welds.push_back(r);
                return;
            end
        end
        limit = (vertex_limit > STORE_DEPTH) ? STORE_DEPTH : int'(vertex_limit);
        if (shadow_total >= limit)
        begin
            r.index = '0;
            r.outcome = STATUS_VERTEX_LIMIT;
            awaited_welds.push_back(r);
            return;
        end
        vertex_store[shadow_total] = c;
        if (have_slot)
            slot_shadow[slot_pick] = SLOT_W'(shadow_total);
        r.index = IDX_W'(shadow_total);
        r.outcome = STATUS_APPENDED;
        awaited_welds.push_back(r);
        shadow_total++;
    endfunction

    function automatic void report_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    // Result checker. done marks a result for exactly one cycle and the block
    // cannot be held off, so every strobe is taken at the edge that ends it.
    always @(posedge clk)
    begin
        weld_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (awaited_welds.size() == 0)
            begin
                report_fault($sformatf("result with nothing expected: index %0d status %0d",
                                       vertex_index, status));
            end
            else
            begin
                want = awaited_welds.pop_front();
                results_checked++;
                status_seen[want.outcome]++;
                if (vertex_index !== want.index)
                    report_fault($sformatf("vertex_index: expected %0d, got %0d",
                                           want.index, vertex_index));
                if (status !== want.outcome)
                    report_fault($sformatf("status: expected %0d, got %0d",
                                           want.outcome, status));
            end
        end
    end

    // Offers one item and waits until the block takes it. start is left high
    // when no idle gap follows, so a following item goes out back to back.
    task automatic send_item(logic clear_item, corner_t c);
        int gap;
        start  <= 1'b1;
        kind   <= clear_item;
        pos_x  <= c[0];
        pos_y  <= c[1];
        pos_z  <= c[2];
        norm_x <= c[3];
        norm_y <= c[4];
        norm_z <= c[5];
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (clear_item)
            clear_shadow();
        else
            weld_corner(c);
        items_sent++;
        gap = 0;
        if (sender_idles)
            while ($urandom_range(99) < 19)
                gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender back until every outstanding result has come.
    task automatic wait_results_drained();
        start <= 1'b0;
        while (awaited_welds.size() != 0)
            @(posedge clk);
    endtask

    // Waits until the block is truly idle. A clear item gives no result, so
    // busy has to be watched too; the extra cycles cover the gap between an
    // acceptance and busy rising.
    task automatic settle_block();
        do
        begin
            wait_results_drained();
            while (busy !== 1'b0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
        while (busy !== 1'b0 || awaited_welds.size() != 0);
    endtask

    // Writes one register; cfg_valid stays high so writes can follow back to back.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            CFG_WELD_ENABLE:     weld_on = value[0];
            CFG_TABLE_SIZE_LOG2: size_log2 = value[3:0];
            CFG_MAX_VERTICES:    vertex_limit = value;
            default:             ;
        endcase
    endtask

    // Rewrites all three registers once the block has gone idle.
    task automatic set_config(logic weld, logic [3:0] lg, logic [CFG_W-1:0] limit);
        settle_block();
        write_register(CFG_WELD_ENABLE, CFG_W'(weld));
        write_register(CFG_TABLE_SIZE_LOG2, CFG_W'(lg));
        write_register(CFG_MAX_VERTICES, limit);
        cfg_valid <= 1'b0;
    endtask

    function automatic corner_t const_corner(logic [WORD_W-1:0] w);
        corner_t c;
        for (int i = 0; i < WORDS; i++)
            c[i] = w;
        return c;
    endfunction

    // Mostly arbitrary bit patterns, with float landmarks mixed in.
    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0] w;
        w = $urandom;
        if ($urandom_range(3) == 0)
        begin
            case ($urandom_range(7))
                0: w = 32'h0000_0000;
                1: w = 32'h8000_0000;
                2: w = 32'h3F80_0000;
                3: w = 32'hBF80_0000;
                4: w = 32'h7F80_0000;
                5: w = 32'h7FC0_0000;
                6: w = 32'hFFFF_FFFF;
                default: w = 32'h0000_0001;
            endcase
        end
        return w;
    endfunction

    function automatic corner_t random_corner();
        corner_t c;
        for (int i = 0; i < WORDS; i++)
            c[i] = random_word();
        return c;
    endfunction

    // Mesh-like traffic: shared corners come back again and again, with some
    // near misses (one bit off), fresh corners, noise and the odd clear.
    task automatic send_mesh_item();
        int      roll;
        corner_t c;
        roll = $urandom_range(99);
        if (roll < 1)
        begin
            send_item(1'b1, random_corner());
        end
        else if (roll < 56 && mesh_pool.size() != 0)
        begin
            send_item(1'b0, mesh_pool[$urandom_range(mesh_pool.size() - 1)]);
        end
        else if (roll < 66 && mesh_pool.size() != 0)
        begin
            c = mesh_pool[$urandom_range(mesh_pool.size() - 1)];
            c[$urandom_range(WORDS - 1)][$urandom_range(WORD_W - 1)] ^= 1'b1;
            send_item(1'b0, c);
        end
        else if (roll < 71)
        begin
            send_item(1'b0, random_corner());
        end
        else
        begin
            c = random_corner();
            mesh_pool.push_back(c);
            if (mesh_pool.size() > POOL_LIMIT)
                void'(mesh_pool.pop_front());
            send_item(1'b0, c);
        end
        // Now and then the sender stops until the block has answered everything.
        if ($urandom_range(59) == 0)
            wait_results_drained();
    endtask

    // Reset settings: appends, reuse, bit-exact compare (negative zero and
    // a single flipped bit are different vertices), and a clear restarting at 0.
    task automatic test_reset_defaults();
        corner_t c;
        send_item(1'b0, const_corner(32'h0000_0000));
        send_item(1'b0, const_corner(32'hFFFF_FFFF));
        send_item(1'b0, const_corner(32'h0000_0000));
        c = const_corner(32'h0000_0000);
        c[0] = 32'h8000_0000;
        send_item(1'b0, c);
        c = const_corner(32'hFFFF_FFFF);
        c[5][0] = 1'b0;
        send_item(1'b0, c);
        send_item(1'b1, const_corner(32'hFFFF_FFFF));
        send_item(1'b0, const_corner(32'hFFFF_FFFF));
    endtask

    // A two-slot table fills after two vertices; a stored corner is still
    // found. A size of zero behaves like a size of one.
    task automatic test_table_full();
        send_item(1'b1, const_corner(32'h0000_0000));
        set_config(1'b1, 4'd1, 13'd4096);
        send_item(1'b0, const_corner(32'h3F80_0000));
        send_item(1'b0, const_corner(32'hBF80_0000));
        send_item(1'b0, const_corner(32'h7FC0_0000));
        send_item(1'b0, const_corner(32'h3F80_0000));
        set_config(1'b1, 4'd0, 13'd4096);
        send_item(1'b0, const_corner(32'h7FC0_0000));
    endtask

    // With room in the table the vertex limit decides, yet a match is reused
    // even at the limit. A limit of zero refuses everything new.
    task automatic test_vertex_limit();
        send_item(1'b1, const_corner(32'h0000_0000));
        set_config(1'b1, 4'd2, 13'd2);
        send_item(1'b0, const_corner(32'h0000_0001));
        send_item(1'b0, const_corner(32'h0000_0002));
        send_item(1'b0, const_corner(32'h0000_0003));
        send_item(1'b0, const_corner(32'h0000_0001));
        set_config(1'b1, 4'd2, 13'd0);
        send_item(1'b0, const_corner(32'h0000_0004));
    endtask

    // Without welding every corner appends up to the vertex limit and the table is
    // left alone, so turning welding back on does not find those vertices.
    task automatic test_weld_disabled();
        send_item(1'b1, const_corner(32'h0000_0000));
        set_config(1'b0, 4'd13, 13'd4096);
        send_item(1'b0, const_corner(32'h0000_0000));
        send_item(1'b0, const_corner(32'h0000_0000));
        set_config(1'b0, 4'd13, 13'd0);
        send_item(1'b0, const_corner(32'h0000_0000));
        set_config(1'b1, 4'd13, 13'd4096);
        send_item(1'b0, const_corner(32'h0000_0000));
    endtask

    // Oversized table and limit settings saturate; shrinking the table
    // without a clear leaves the outer slots out of the probe.
    task automatic test_size_extremes();
        set_config(1'b1, 4'd15, 13'd8191);
        send_item(1'b0, const_corner(32'h7F80_0000));
        set_config(1'b1, 4'd14, 13'd8191);
        send_item(1'b0, const_corner(32'h7F80_0000));
        set_config(1'b1, 4'd3, 13'd4096);
        send_item(1'b0, const_corner(32'h7F80_0000));
        send_item(1'b0, random_corner());
    endtask

    // Random phases, each with a fresh register setting and, at random, a clear.
    task automatic test_random_mesh();
        int               roll;
        logic             weld;
        logic [3:0]       lg;
        logic [CFG_W-1:0] limit;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if ($urandom_range(1) == 0)
                send_item(1'b1, random_corner());
            roll = $urandom_range(9);
            if (roll < 4)
                lg = 4'($urandom_range(1, 4));
            else if (roll < 8)
                lg = 4'($urandom_range(5, 13));
            else
            begin
                case ($urandom_range(2))
                    0:       lg = 4'd0;
                    1:       lg = 4'd14;
                    default: lg = 4'd15;
                endcase
            end
            weld = ($urandom_range(99) < 85);
            roll = $urandom_range(9);
            if (roll < 5)
                limit = 13'd4096;
            else if (roll < 7)
                limit = CFG_W'($urandom_range(0, 8191));
            else
                limit = CFG_W'($urandom_range(0, 64));
            set_config(weld, lg, limit);
            // Phases 10 to 12 run back to back with no idle cycles.
            sender_idles = !(phase >= 10 && phase < 13);
            repeat (ITEMS_PER_PHASE) send_mesh_item();
        end
        sender_idles = 1'b1;
    endtask

    initial
    begin
        weld_on = 1'b1;
        size_log2 = 4'd13;
        vertex_limit = 13'd4096;
        clear_shadow();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // The block sweeps its table after reset; send_item waits on busy.
        test_reset_defaults();
        test_table_full();
        test_vertex_limit();
        test_weld_disabled();
        test_size_extremes();
        test_random_mesh();

        wait_results_drained();
        repeat (60) @(posedge clk);
        if (awaited_welds.size() != 0)
            report_fault($sformatf("%0d results never arrived", awaited_welds.size()));

        $display("Sent %0d items; checked %0d corner results over %0d register settings.",
                 items_sent, results_checked, RANDOM_PHASES);
        $display("Outcomes: %0d appended, %0d reused, %0d table full, %0d at vertex limit.",
                 status_seen[STATUS_APPENDED], status_seen[STATUS_REUSED],
                 status_seen[STATUS_TABLE_FULL], status_seen[STATUS_VERTEX_LIMIT]);
        if (fault_count == 0)
            $display("vertex_weld_hash_table_test: clean");
        else
            $display("vertex_weld_hash_table_test: errors");
        $finish;
    end

    // Guard against a hung handshake: several times the longest expected run.
    initial
    begin
        #60_000_000;
        $display("vertex_weld_hash_table_test: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/vwht_pkg.sv
hdl/vwht_ram.sv
hdl/vertex_weld_hash_table.sv
hdl/vwht_checker.sv
sim/vertex_weld_hash_table_test.sv
